// ===== rtl/jhg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhg_pkg
// Shared types and codes for the Jacobi heat grid solver.
// ----------------------------------------------------------------------------
package jhg_pkg;

  // command codes
  localparam logic [1:0] FN_WRITE  = 2'd0;
  localparam logic [1:0] FN_SOURCE = 2'd1;
  localparam logic [1:0] FN_RUN    = 2'd2;
  localparam logic [1:0] FN_READ   = 2'd3;

  // result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_RANGE = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_COLS  = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;
  localparam logic [1:0] REG_MAXIT = 2'd3;

  // fixed point 1.0
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  typedef struct packed {
    logic [6:0]  grid_cols;
    logic [6:0]  grid_rows;
    logic [15:0] convergence_limit;
    logic [15:0] max_iterations;
  } cfg_t;

endpackage

// ===== rtl/jacobi_heat_grid_solver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jacobi_heat_grid_solver_unit
// Jacobi heat diffusion solver over a Q1.15 grid held in two RAMs.
// ----------------------------------------------------------------------------
// channel   direction  handshake                    payload
// command   in         start & !busy                func, row, col, value
// result    out        done (one-cycle strobe)      status, read_value,
//                                                   iterations, final_error
// config    in         psel & penable & pwrite      paddr, pwdata / prdata
//
// Write, source and read commands are taken while idle; the result beat
// follows in the next cycle and busy stays low, so one command per cycle
// as long as no run holds busy. A run makes five reads per interior cell
// through the single current-grid read port, copies the interior back, and
// forces a 3x3 block around each source that fits (one that does not is
// skipped); a check precedes each sweep, and a final check the result beat.
// Reset is synchronous; grid memories are not cleared. Results cannot stall.
// ----------------------------------------------------------------------------
module jacobi_heat_grid_solver_unit #(
  parameter int MAX_COLS    = 64,
  parameter int MAX_ROWS    = 64,
  parameter int MAX_SOURCES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [5:0]  row,
  input  logic [5:0]  col,
  input  logic [15:0] value,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] read_value,
  output logic [15:0] iterations,
  output logic [15:0] final_error,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  jhg_pkg::cfg_t cfg;
  logic          a_we, b_we;
  logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
  logic [15:0]   a_wdata, a_rdata, b_wdata, b_rdata;

  jhg_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  jhg_engine #(
    .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .MAX_SOURCES(MAX_SOURCES)
  ) u_engine (
    .clk, .rst, .cfg, .start, .func, .row, .col, .value, .busy, .done, .status,
    .read_value, .iterations, .final_error,
    .a_we, .a_waddr, .a_wdata, .a_raddr, .a_rdata,
    .b_we, .b_waddr, .b_wdata, .b_raddr, .b_rdata
  );

  // current grid
  jhg_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_cur (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_rdata)
  );

  // next grid
  jhg_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_nxt (
    .clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(b_raddr), .rdata(b_rdata)
  );

endmodule

// ===== rtl/jhg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhg_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module jhg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/jhg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhg_regs
// APB configuration registers: grid size, convergence limit, sweep limit.
// ----------------------------------------------------------------------------
module jhg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output jhg_pkg::cfg_t       cfg
);

  logic       wr_en;
  logic [1:0] index;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign index  = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_cols         <= 7'd64;
      cfg.grid_rows         <= 7'd64;
      cfg.convergence_limit <= 16'd33;
      cfg.max_iterations    <= 16'd1000;
    end else if (wr_en) begin
      case (index)
        jhg_pkg::REG_COLS:  cfg.grid_cols         <= pwdata[6:0];
        jhg_pkg::REG_ROWS:  cfg.grid_rows         <= pwdata[6:0];
        jhg_pkg::REG_LIMIT: cfg.convergence_limit <= pwdata[15:0];
        jhg_pkg::REG_MAXIT: cfg.max_iterations    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (index)
      jhg_pkg::REG_COLS:  prdata = {25'd0, cfg.grid_cols};
      jhg_pkg::REG_ROWS:  prdata = {25'd0, cfg.grid_rows};
      jhg_pkg::REG_LIMIT: prdata = {16'd0, cfg.convergence_limit};
      jhg_pkg::REG_MAXIT: prdata = {16'd0, cfg.max_iterations};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/jhg_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jhg_engine
// Command decode, source table and the sweep / copy / force sequencer that
// drives the current and next grid memories.
// ----------------------------------------------------------------------------
module jhg_engine #(
  parameter int MAX_COLS    = 64,
  parameter int MAX_ROWS    = 64,
  parameter int MAX_SOURCES = 8,
  localparam int AW = $clog2(MAX_ROWS * MAX_COLS)
) (
  input  logic           clk,
  input  logic           rst,
  input  jhg_pkg::cfg_t  cfg,
  input  logic           start,
  input  logic [1:0]     func,
  input  logic [5:0]     row,
  input  logic [5:0]     col,
  input  logic [15:0]    value,
  output logic           busy,
  output logic           done,
  output logic [1:0]     status,
  output logic [15:0]    read_value,
  output logic [15:0]    iterations,
  output logic [15:0]    final_error,
  output logic           a_we,
  output logic [AW-1:0]  a_waddr,
  output logic [15:0]    a_wdata,
  output logic [AW-1:0]  a_raddr,
  input  logic [15:0]    a_rdata,
  output logic           b_we,
  output logic [AW-1:0]  b_waddr,
  output logic [15:0]    b_wdata,
  output logic [AW-1:0]  b_raddr,
  input  logic [15:0]    b_rdata
);

  localparam int MAXD = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int DW   = $clog2(MAXD + 1);
  localparam int SW   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CW   = $clog2(MAX_SOURCES + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_COPY  = 3'd3;
  localparam logic [2:0] ST_FBASE = 3'd4;
  localparam logic [2:0] ST_FORCE = 3'd5;

  logic [2:0]    state;
  logic [2:0]    phase;
  logic [DW-1:0] r, c;
  logic [AW-1:0] idx;
  logic [17:0]   acc;
  logic [15:0]   old;
  logic [15:0]   maxerr;
  logic [15:0]   err;
  logic [15:0]   n;
  logic [CW-1:0] s_idx;
  logic [1:0]    fdr, fdc;
  logic [AW-1:0] faddr;
  logic [5:0]    src_row [MAX_SOURCES];
  logic [5:0]    src_col [MAX_SOURCES];
  logic [CW-1:0] src_cnt;
  logic          rd_pend;

  logic [DW-1:0] cols, rows;
  logic          accept, in_grid, src_ok, row_end, grid_end, last_src, src_fit;
  logic [AW-1:0] cell_addr, first_idx, fbase;
  logic [17:0]   sum;
  logic [15:0]   avg, diff;
  logic [5:0]    sr, sc;

  // clamp the grid size to the supported range
  always_comb begin
    if (cfg.grid_cols < 7'd3) cols = DW'(3);
    else if (32'(cfg.grid_cols) > MAX_COLS) cols = DW'(MAX_COLS);
    else cols = DW'(cfg.grid_cols);
    if (cfg.grid_rows < 7'd3) rows = DW'(3);
    else if (32'(cfg.grid_rows) > MAX_ROWS) rows = DW'(MAX_ROWS);
    else rows = DW'(cfg.grid_rows);
  end

  assign busy      = (state != ST_IDLE);
  assign accept    = start & ~busy;
  assign in_grid   = (32'(row) < 32'(rows)) && (32'(col) < 32'(cols));
  assign src_ok    = (row != 6'd0) && (32'(row) + 32'd2 <= 32'(rows)) &&
                     (col != 6'd0) && (32'(col) + 32'd2 <= 32'(cols));
  assign cell_addr = AW'(32'(row) * 32'(cols) + 32'(col));
  assign first_idx = AW'(32'(cols) + 32'd1);

  // interior walk bookkeeping
  assign row_end  = (32'(c) + 32'd2 == 32'(cols));
  assign grid_end = (32'(r) + 32'd2 == 32'(rows));

  // neighbor average and change
  assign sum  = acc + 18'(a_rdata);
  assign avg  = sum[17:2];
  assign diff = (avg > old) ? (avg - old) : (old - avg);

  // source block placement
  assign sr       = src_row[s_idx[SW-1:0]];
  assign sc       = src_col[s_idx[SW-1:0]];
  assign src_fit  = (sr != 6'd0) && (32'(sr) + 32'd2 <= 32'(rows)) &&
                    (sc != 6'd0) && (32'(sc) + 32'd2 <= 32'(cols));
  assign fbase    = AW'((32'(sr) - 32'd1) * 32'(cols) + 32'(sc) - 32'd1);
  assign last_src = (s_idx + CW'(1) == src_cnt);

  // memory port steering
  always_comb begin
    a_we    = 1'b0;
    a_waddr = idx;
    a_wdata = b_rdata;
    a_raddr = cell_addr;
    b_we    = 1'b0;
    b_waddr = idx;
    b_wdata = avg;
    b_raddr = idx;
    case (state)
      ST_IDLE: begin
        a_we    = accept && (func == jhg_pkg::FN_WRITE) && in_grid;
        a_waddr = cell_addr;
        a_wdata = value;
      end
      ST_SWEEP: begin
        case (phase)
          3'd0:    a_raddr = idx;
          3'd1:    a_raddr = idx - AW'(1);
          3'd2:    a_raddr = idx + AW'(1);
          3'd3:    a_raddr = idx - AW'(cols);
          default: a_raddr = idx + AW'(cols);
        endcase
        b_we = (phase == 3'd5);
      end
      ST_COPY: begin
        a_we = (phase == 3'd1);
      end
      ST_FORCE: begin
        a_we    = 1'b1;
        a_waddr = faddr;
        a_wdata = jhg_pkg::ONE_Q15;
      end
      default: ;
    endcase
  end

  assign read_value = rd_pend ? a_rdata : 16'd0;

  // source table
  always_ff @(posedge clk) begin
    if (accept && func == jhg_pkg::FN_SOURCE && src_ok && 32'(src_cnt) < MAX_SOURCES) begin
      src_row[src_cnt[SW-1:0]] <= row;
      src_col[src_cnt[SW-1:0]] <= col;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      done    <= 1'b0;
      rd_pend <= 1'b0;
      src_cnt <= '0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            iterations  <= 16'd0;
            final_error <= 16'd0;
            status      <= jhg_pkg::STS_OK;
            case (func)
              jhg_pkg::FN_WRITE: begin
                done <= 1'b1;
                if (!in_grid) status <= jhg_pkg::STS_RANGE;
              end
              jhg_pkg::FN_SOURCE: begin
                done <= 1'b1;
                if (!src_ok) status <= jhg_pkg::STS_RANGE;
                else if (32'(src_cnt) >= MAX_SOURCES) status <= jhg_pkg::STS_FULL;
                else src_cnt <= src_cnt + CW'(1);
              end
              jhg_pkg::FN_RUN: begin
                err   <= jhg_pkg::ONE_Q15;
                n     <= 16'd0;
                state <= ST_CHECK;
              end
              default: begin
                done    <= 1'b1;
                rd_pend <= in_grid;
                if (!in_grid) status <= jhg_pkg::STS_RANGE;
              end
            endcase
          end
        end
        ST_CHECK: begin
          if (n < cfg.max_iterations && err > cfg.convergence_limit) begin
            r      <= DW'(1);
            c      <= DW'(1);
            idx    <= first_idx;
            phase  <= 3'd0;
            maxerr <= 16'd0;
            state  <= ST_SWEEP;
          end else begin
            done        <= 1'b1;
            status      <= jhg_pkg::STS_OK;
            iterations  <= n;
            final_error <= err;
            state       <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          phase <= phase + 3'd1;
          if (phase == 3'd1) begin
            old <= a_rdata;
            acc <= 18'd0;
          end else if (phase != 3'd0 && phase != 3'd5) begin
            acc <= sum;
          end
          if (phase == 3'd5) begin
            phase <= 3'd0;
            if (diff > maxerr) maxerr <= diff;
            if (row_end) begin
              c <= DW'(1);
              if (grid_end) begin
                r     <= DW'(1);
                idx   <= first_idx;
                state <= ST_COPY;
              end else begin
                r   <= r + DW'(1);
                idx <= idx + AW'(3);
              end
            end else begin
              c   <= c + DW'(1);
              idx <= idx + AW'(1);
            end
          end
        end
        ST_COPY: begin
          phase <= (phase == 3'd0) ? 3'd1 : 3'd0;
          if (phase == 3'd1) begin
            if (row_end) begin
              c <= DW'(1);
              if (grid_end) begin
                s_idx <= '0;
                if (src_cnt == '0) begin
                  n     <= n + 16'd1;
                  err   <= maxerr;
                  state <= ST_CHECK;
                end else begin
                  state <= ST_FBASE;
                end
              end else begin
                r   <= r + DW'(1);
                idx <= idx + AW'(3);
              end
            end else begin
              c   <= c + DW'(1);
              idx <= idx + AW'(1);
            end
          end
        end
        ST_FBASE: begin
          fdr   <= 2'd0;
          fdc   <= 2'd0;
          faddr <= fbase;
          if (src_fit) begin
            state <= ST_FORCE;
          end else if (last_src) begin
            n     <= n + 16'd1;
            err   <= maxerr;
            state <= ST_CHECK;
          end else begin
            s_idx <= s_idx + CW'(1);
          end
        end
        ST_FORCE: begin
          if (fdc != 2'd2) begin
            fdc   <= fdc + 2'd1;
            faddr <= faddr + AW'(1);
          end else begin
            fdc <= 2'd0;
            if (fdr != 2'd2) begin
              fdr   <= fdr + 2'd1;
              faddr <= faddr + AW'(cols) - AW'(2);
            end else if (last_src) begin
              n     <= n + 16'd1;
              err   <= maxerr;
              state <= ST_CHECK;
            end else begin
              s_idx <= s_idx + CW'(1);
              state <= ST_FBASE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");
  a_sweep_no_a_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> !a_we)
    else $error("current grid written during sweep");
  a_src_count: assert property (@(posedge clk) disable iff (rst)
    32'(src_cnt) <= MAX_SOURCES)
    else $error("source count overflow");
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start) && ($past(func) == jhg_pkg::FN_RUN))
    else $error("busy without run command");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Jacobi heat grid solver unit. Commands (cell
// write, heat source, solver run, cell read) go in through the start/busy
// port, and each result beat is checked against a bit-exact Q1.15 grid model.
// The registers are set over APB between phases. A directed part is followed
// by three series of random phases, each series under its own sender idle rate.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CELLS      = 4096;
  localparam int NSRC       = 8;
  localparam int STALL_MAX  = 200000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] read_value;
    logic [15:0] iterations;
    logic [15:0] final_error;
  } result_t;

  logic        clk, rst, start, busy, done, psel, penable, pwrite, pready;
  logic [1:0]  func, status;
  logic [5:0]  row, col;
  logic [15:0] value, read_value, iterations, final_error;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  jacobi_heat_grid_solver_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .row(row), .col(col), .value(value),
    .done(done), .status(status), .read_value(read_value),
    .iterations(iterations), .final_error(final_error),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // grid model state
  logic [15:0]   heat_cur [CELLS];
  logic [15:0]   heat_nxt [CELLS];
  bit            cell_set [CELLS];
  logic [5:0]    src_r [NSRC];
  logic [5:0]    src_c [NSRC];
  int            src_n;
  jhg_pkg::cfg_t regs;

  result_t     pending_results[$];
  int          errors, n_results, n_runs, n_sweeps, n_phases;
  int          sender_idle_pct;
  int          stall_cnt;

  function automatic int clamp_dim(logic [6:0] v);
    if (v < 7'd3) return 3;
    if (v > 7'd64) return 64;
    return int'(v);
  endfunction

  // 3x3 blocks around every source that still fits
  function automatic void force_heat_blocks(int rows, int cols);
    int r, c, idx;
    for (int s = 0; s < src_n; s++) begin
      r = int'(src_r[s]);
      c = int'(src_c[s]);
      if (r < 1 || r + 2 > rows || c < 1 || c + 2 > cols) continue;
      for (int dr = 0; dr < 3; dr++) begin
        for (int dc = 0; dc < 3; dc++) begin
          idx = (r - 1 + dr) * cols + (c - 1 + dc);
          heat_cur[idx] = jhg_pkg::ONE_Q15;
          heat_nxt[idx] = jhg_pkg::ONE_Q15;
          cell_set[idx] = 1'b1;
        end
      end
    end
  endfunction

  // one Jacobi pass, returns largest change
  function automatic logic [15:0] jacobi_sweep(int rows, int cols);
    logic [17:0] sum;
    logic [15:0] avg, delta, worst;
    int idx;
    worst = '0;
    for (int r = 1; r + 1 < rows; r++) begin
      for (int c = 1; c + 1 < cols; c++) begin
        idx = r * cols + c;
        sum = 18'(heat_cur[idx + 1]) + 18'(heat_cur[idx - 1])
            + 18'(heat_cur[idx - cols]) + 18'(heat_cur[idx + cols]);
        avg = sum[17:2];
        delta = (avg > heat_cur[idx]) ? avg - heat_cur[idx] : heat_cur[idx] - avg;
        heat_nxt[idx] = avg;
        if (delta > worst) worst = delta;
      end
    end
    for (int r = 1; r + 1 < rows; r++)
      for (int c = 1; c + 1 < cols; c++)
        heat_cur[r * cols + c] = heat_nxt[r * cols + c];
    force_heat_blocks(rows, cols);
    return worst;
  endfunction

  function automatic result_t solve_cmd(logic [1:0] f, logic [5:0] r, logic [5:0] c,
                                        logic [15:0] v);
    result_t res;
    int cols, rows, idx;
    logic [15:0] err;
    bit in_grid;
    res = '0;
    cols = clamp_dim(regs.grid_cols);
    rows = clamp_dim(regs.grid_rows);
    in_grid = (int'(r) < rows) && (int'(c) < cols);
    idx = int'(r) * cols + int'(c);
    case (f)
      jhg_pkg::FN_WRITE: begin
        if (in_grid) begin
          heat_cur[idx] = v;
          cell_set[idx] = 1'b1;
        end else res.status = jhg_pkg::STS_RANGE;
      end
      jhg_pkg::FN_SOURCE: begin
        if (int'(r) < 1 || int'(r) + 2 > rows || int'(c) < 1 || int'(c) + 2 > cols)
          res.status = jhg_pkg::STS_RANGE;
        else if (src_n >= NSRC) res.status = jhg_pkg::STS_FULL;
        else begin
          src_r[src_n] = r;
          src_c[src_n] = c;
          src_n++;
        end
      end
      jhg_pkg::FN_RUN: begin
        err = jhg_pkg::ONE_Q15;
        res.iterations = '0;
        while (res.iterations < regs.max_iterations && err > regs.convergence_limit) begin
          err = jacobi_sweep(rows, cols);
          res.iterations++;
        end
        res.final_error = err;
        n_runs++;
        n_sweeps += int'(res.iterations);
      end
      default: begin
        if (in_grid) res.read_value = heat_cur[idx];
        else res.status = jhg_pkg::STS_RANGE;
      end
    endcase
    return res;
  endfunction

  // every cell of the grid in use has been written
  function automatic bit grid_loaded();
    int n;
    n = clamp_dim(regs.grid_cols) * clamp_dim(regs.grid_rows);
    for (int i = 0; i < n; i++)
      if (!cell_set[i]) return 1'b0;
    return 1'b1;
  endfunction

  // send one command beat, predict at acceptance
  task automatic send_cmd(logic [1:0] f, logic [5:0] r, logic [5:0] c, logic [15:0] v);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    func  <= f;
    row   <= r;
    col   <= c;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(solve_cmd(f, r, c, v));
  endtask

  // stop sending and wait for every result
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup and access phases, then the bus returns to idle
  task automatic apb_write(logic [1:0] idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      jhg_pkg::REG_COLS:  regs.grid_cols = data[6:0];
      jhg_pkg::REG_ROWS:  regs.grid_rows = data[6:0];
      jhg_pkg::REG_LIMIT: regs.convergence_limit = data[15:0];
      jhg_pkg::REG_MAXIT: regs.max_iterations = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [6:0] cols, logic [6:0] rows, logic [15:0] lim,
                          logic [15:0] maxit);
    drain();
    apb_write(jhg_pkg::REG_COLS, 32'(cols));
    apb_write(jhg_pkg::REG_ROWS, 32'(rows));
    apb_write(jhg_pkg::REG_LIMIT, 32'(lim));
    apb_write(jhg_pkg::REG_MAXIT, 32'(maxit));
  endtask

  task automatic load_grid();
    for (int r = 0; r < clamp_dim(regs.grid_rows); r++)
      for (int c = 0; c < clamp_dim(regs.grid_cols); c++)
        send_cmd(jhg_pkg::FN_WRITE, 6'(r), 6'(c),
                 ($urandom_range(3) == 0) ? jhg_pkg::ONE_Q15 : 16'($urandom));
  endtask

  // directed: corners, clamping, extremes, sources, zero limit
  task automatic test_directed();
    sender_idle_pct = 0;
    send_cmd(jhg_pkg::FN_WRITE, 6'd0, 6'd0, 16'h0000);
    send_cmd(jhg_pkg::FN_WRITE, 6'd63, 6'd63, 16'hFFFF);
    send_cmd(jhg_pkg::FN_READ, 6'd63, 6'd63, 16'h0);
    send_cmd(jhg_pkg::FN_READ, 6'd0, 6'd0, 16'h0);
    send_cmd(jhg_pkg::FN_SOURCE, 6'd0, 6'd5, 16'h0);
    send_cmd(jhg_pkg::FN_SOURCE, 6'd62, 6'd62, 16'h0);
    send_cmd(jhg_pkg::FN_SOURCE, 6'd63, 6'd1, 16'h0);
    // zero iteration limit, clamped sizes
    set_regs(7'd0, 7'd127, 16'd0, 16'd0);
    send_cmd(jhg_pkg::FN_RUN, 6'd0, 6'd0, 16'h0);
    send_cmd(jhg_pkg::FN_WRITE, 6'd5, 6'd3, 16'h1234);
    send_cmd(jhg_pkg::FN_READ, 6'd5, 6'd3, 16'h0);
    send_cmd(jhg_pkg::FN_WRITE, 6'd2, 6'd2, 16'h4321);
    send_cmd(jhg_pkg::FN_READ, 6'd2, 6'd2, 16'h0);
    // smallest grid, single sweep
    set_regs(7'd3, 7'd3, 16'd0, 16'd1);
    for (int i = 0; i < 9; i++)
      send_cmd(jhg_pkg::FN_WRITE, 6'(i / 3), 6'(i % 3), 16'(i * 7000));
    send_cmd(jhg_pkg::FN_RUN, 6'd0, 6'd0, 16'h0);
    send_cmd(jhg_pkg::FN_READ, 6'd1, 6'd1, 16'h0);
    // iteration limit of three, with a source
    set_regs(7'd3, 7'd3, 16'd0, 16'd3);
    send_cmd(jhg_pkg::FN_SOURCE, 6'd1, 6'd1, 16'h0);
    send_cmd(jhg_pkg::FN_RUN, 6'd0, 6'd0, 16'h0);
    // table fills up
    for (int i = 0; i < 7; i++) send_cmd(jhg_pkg::FN_SOURCE, 6'd1, 6'd1, 16'h0);
    send_cmd(jhg_pkg::FN_READ, 6'd1, 6'd2, 16'h0);
  endtask

  // random phases: new sizes, full grid load except in the last phase, then a command mix
  task automatic test_random(int idle_pct, int phases);
    int pick, cols, rows;
    logic [15:0] lim, maxit;
    logic [5:0] r, c;
    bit big_phase;
    sender_idle_pct = idle_pct;
    for (int p = 0; p < phases; p++) begin
      big_phase = (p == phases - 1);
      n_phases++;
      if (big_phase) begin
        cols = int'($urandom_range(40, 127));
        rows = int'($urandom_range(40, 127));
        maxit = 16'd0;
        lim = 16'($urandom);
      end else begin
        cols = int'(($urandom_range(5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8));
        rows = int'(($urandom_range(5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8));
        case ($urandom_range(3))
          0: begin maxit = 16'hFFFF; lim = 16'hFFFF; end
          1: begin maxit = 16'($urandom_range(0, 20)); lim = 16'd0; end
          2: begin maxit = 16'($urandom_range(1, 20)); lim = 16'($urandom); end
          default: begin
            maxit = 16'($urandom_range(1, 20));
            lim = 16'($urandom_range(0, 300));
          end
        endcase
      end
      set_regs(7'(cols), 7'(rows), lim, maxit);
      if (!big_phase) load_grid();
      for (int k = 0; k < 40; k++) begin
        pick = int'($urandom_range(99));
        if ($urandom_range(3) == 0) begin
          r = 6'($urandom);
          c = 6'($urandom);
        end else begin
          r = 6'($urandom_range(clamp_dim(regs.grid_rows) - 1));
          c = 6'($urandom_range(clamp_dim(regs.grid_cols) - 1));
        end
        if (pick < 10) send_cmd(jhg_pkg::FN_SOURCE, r, c, 16'($urandom));
        else if (pick < 20 && (regs.max_iterations == 16'd0 || grid_loaded()))
          send_cmd(jhg_pkg::FN_RUN, r, c, 16'($urandom));
        else if (pick < 60 && (int'(r) >= clamp_dim(regs.grid_rows) ||
                 int'(c) >= clamp_dim(regs.grid_cols) ||
                 cell_set[int'(r) * clamp_dim(regs.grid_cols) + int'(c)]))
          send_cmd(jhg_pkg::FN_READ, r, c, 16'($urandom));
        else send_cmd(jhg_pkg::FN_WRITE, r, c, 16'($urandom));
      end
      // after the second phase, wait for every pending result
      if (p == 1) drain();
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_t exp_res;
    if (!rst && done) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat status=%0d rd=%h it=%0d err=%h", $time,
                 status, read_value, iterations, final_error);
        errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (status !== exp_res.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_res.status, status);
          errors++;
        end
        if (read_value !== exp_res.read_value) begin
          $display("%0t: read_value exp %h got %h", $time, exp_res.read_value, read_value);
          errors++;
        end
        if (iterations !== exp_res.iterations) begin
          $display("%0t: iterations exp %0d got %0d", $time, exp_res.iterations, iterations);
          errors++;
        end
        if (final_error !== exp_res.final_error) begin
          $display("%0t: final_error exp %h got %h", $time, exp_res.final_error,
                   final_error);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_MAX) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = jhg_pkg::FN_WRITE;
    row = '0;
    col = '0;
    value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    n_results = 0;
    n_runs = 0;
    n_sweeps = 0;
    n_phases = 0;
    sender_idle_pct = 0;
    stall_cnt = 0;
    src_n = 0;
    regs = '{grid_cols: 7'd64, grid_rows: 7'd64, convergence_limit: 16'd33,
             max_iterations: 16'd1000};
    for (int i = 0; i < CELLS; i++) begin
      heat_cur[i] = '0;
      heat_nxt[i] = '0;
      cell_set[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(11, 5);
    test_random(53, 5);
    test_random(0, 5);
    drain();
    repeat (20) @(posedge clk);

    $display("Checked %0d result beats over %0d random phases.", n_results, n_phases);
    $display("Solver runs: %0d, total sweeps: %0d.", n_runs, n_sweeps);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/jhg_pkg.sv
rtl/jhg_ram.sv
rtl/jhg_regs.sv
rtl/jhg_engine.sv
rtl/jacobi_heat_grid_solver_unit.sv
tb/testbench.sv
